// ----- hw/rtl/tfn_pkg.sv -----
// Shared types and codes for the triangle face normal store.
`timescale 1ns / 1ps
package tfn_pkg;
  localparam int DEFAULT_VERTEX_DEPTH = 4096;
  localparam int IDX_W = 17;

  localparam logic [1:0] CMD_VERTEX = 2'd0;
  localparam logic [1:0] CMD_FACE   = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_DEGEN = 2'd3;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][29:0] mag;
  } xprod_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } xprod_ctl_t;
endpackage

// ----- hw/rtl/tfn_cross_unit.sv -----
// Five-stage pipeline: edges, edge scaling, products, cross product, cross scaling.
`timescale 1ns / 1ps
module tfn_cross_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [95:0]         va,
  input  logic [95:0]         vb,
  input  logic [95:0]         vc,
  output tfn_pkg::xprod_ctl_t ctl,
  output tfn_pkg::xprod_t     xprod
);
  import tfn_pkg::*;

  logic [4:0]         vld;
  logic signed [32:0] ed [6];
  logic signed [32:0] ed_next [6];
  logic [5:0]         esgn;
  logic [29:0]        emag [6];
  logic [29:0]        emag_next [6];
  logic [5:0]         psgn;
  logic [59:0]        pmag [6];
  logic signed [62:0] cval [3];
  logic signed [62:0] cval_next [3];
  logic [32:0]        m33 [6];
  logic [32:0]        or33;
  logic [1:0]         esh;
  logic [61:0]        cmag [3];
  logic [61:0]        or62;
  logic [5:0]         top;
  logic [5:0]         csh;
  logic signed [62:0] sv [6];
  logic               zero;
  logic               zero_q;
  xprod_t             xp_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ed_next[k] = $signed({vb[32*k+31], vb[32*k +: 32]})
                 - $signed({va[32*k+31], va[32*k +: 32]});
      ed_next[k+3] = $signed({vc[32*k+31], vc[32*k +: 32]})
                   - $signed({va[32*k+31], va[32*k +: 32]});
    end
  end

  always_comb begin
    or33 = '0;
    for (int i = 0; i < 6; i++) begin
      m33[i] = ed[i][32] ? 33'(-ed[i]) : 33'(ed[i]);
      or33   = or33 | m33[i];
    end
    if (or33[32])      esh = 2'd3;
    else if (or33[31]) esh = 2'd2;
    else if (or33[30]) esh = 2'd1;
    else               esh = 2'd0;
    for (int i = 0; i < 6; i++) emag_next[i] = 30'(m33[i] >> esh);
  end

  always_comb begin
    for (int i = 0; i < 6; i++)
      sv[i] = psgn[i] ? -$signed({3'b000, pmag[i]}) : $signed({3'b000, pmag[i]});
    for (int k = 0; k < 3; k++) cval_next[k] = sv[2*k] - sv[2*k+1];
  end

  always_comb begin
    or62 = '0;
    for (int k = 0; k < 3; k++) begin
      cmag[k] = cval[k][62] ? 62'(-cval[k]) : 62'(cval[k]);
      or62    = or62 | cmag[k];
    end
    top = '0;
    for (int b = 0; b < 62; b++) if (or62[b]) top = 6'(b);
    csh  = (top >= 6'd30) ? top - 6'd29 : 6'd0;
    zero = (or62 == '0);
    for (int k = 0; k < 3; k++) begin
      xp_next.neg[k] = cval[k][62];
      xp_next.mag[k] = 30'(cmag[k] >> csh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    ed <= ed_next;
    for (int i = 0; i < 6; i++) esgn[i] <= ed[i][32];
    emag <= emag_next;
    psgn[0] <= esgn[1] ^ esgn[5];
    psgn[1] <= esgn[2] ^ esgn[4];
    psgn[2] <= esgn[2] ^ esgn[3];
    psgn[3] <= esgn[0] ^ esgn[5];
    psgn[4] <= esgn[0] ^ esgn[4];
    psgn[5] <= esgn[1] ^ esgn[3];
    pmag[0] <= emag[1] * emag[5];
    pmag[1] <= emag[2] * emag[4];
    pmag[2] <= emag[2] * emag[3];
    pmag[3] <= emag[0] * emag[5];
    pmag[4] <= emag[0] * emag[4];
    pmag[5] <= emag[1] * emag[3];
    cval <= cval_next;
    xprod <= xp_next;
    zero_q <= zero;
  end

  assign ctl = '{valid: vld[4], zero: zero_q};
endmodule

// ----- hw/rtl/tfn_norm_unit.sv -----
// Length by bit-serial square root, then one serial divider shared by the components in turn.
`timescale 1ns / 1ps
module tfn_norm_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tfn_pkg::xprod_t xprod,
  output logic            done,
  output logic [47:0]     normal
);
  import tfn_pkg::*;

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_SUM  = 3'd2;
  localparam logic [2:0] N_ROOT = 3'd3;
  localparam logic [2:0] N_LOAD = 3'd4;
  localparam logic [2:0] N_DIV  = 3'd5;

  logic [2:0]        state;
  logic [4:0]        cnt;
  logic [1:0]        comp;
  logic [2:0]        cn;
  logic [2:0][29:0]  cm;
  logic [59:0]       sq [3];
  logic [61:0]       rad;
  logic [33:0]       rrem;
  logic [30:0]       root;
  logic [33:0]       remsh;
  logic [33:0]       trial;
  logic [46:0]       num;
  logic [16:0]       dnum;
  logic [32:0]       drem;
  logic [32:0]       dsh;
  logic [32:0]       dden;
  logic [16:0]       quo;
  logic              qbit;
  logic [16:0]       qn;
  logic [15:0]       sat;
  logic [2:0][15:0]  res;

  always_comb begin
    remsh = {rrem[31:0], rad[61:60]};
    trial = {1'b0, root, 2'b01};
    num   = {1'b0, cm[comp], 16'b0} + 47'(root);
    dsh   = {drem[31:0], dnum[16]};
    dden  = {1'b0, root, 1'b0};
    qbit  = (dsh >= dden);
    qn    = {quo[15:0], qbit};
    if (cn[comp]) sat = (qn > 17'd32768) ? 16'h8000 : 16'(17'd0 - qn);
    else          sat = (qn > 17'd32767) ? 16'h7fff : qn[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            cm    <= xprod.mag;
            cn    <= xprod.neg;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          for (int k = 0; k < 3; k++) sq[k] <= cm[k] * cm[k];
          state <= N_SUM;
        end
        N_SUM: begin
          rad   <= 62'(sq[0]) + 62'(sq[1]) + 62'(sq[2]);
          rrem  <= '0;
          root  <= '0;
          cnt   <= 5'd30;
          state <= N_ROOT;
        end
        N_ROOT: begin
          if (remsh >= trial) begin
            rrem <= remsh - trial;
            root <= {root[29:0], 1'b1};
          end else begin
            rrem <= remsh;
            root <= {root[29:0], 1'b0};
          end
          rad <= {rad[59:0], 2'b00};
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            comp  <= 2'd0;
            state <= N_LOAD;
          end
        end
        N_LOAD: begin
          drem  <= 33'(num[46:17]);
          dnum  <= num[16:0];
          quo   <= '0;
          cnt   <= 5'd16;
          state <= N_DIV;
        end
        N_DIV: begin
          drem <= qbit ? dsh - dden : dsh;
          dnum <= {dnum[15:0], 1'b0};
          quo  <= qn;
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            res[comp] <= sat;
            if (comp == 2'd2) begin
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_LOAD;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign normal = res;
endmodule

// ----- hw/rtl/triangle_face_normal_store_unit.sv -----
// Face items: three corner reads, 5 cross stages, norm unit for a nonzero product
// (square, sum, 31 root steps, a load and serial divide per component), 3 normal writes.
// Vertex, query and unused items skip these; next accept as the result appears.
// One request in flight; a finished result may wait in the output register.
// Synchronous reset clears the vertex count and control; an append writes a zero
// normal to its entry, so no clearing pass runs after reset.
`timescale 1ns / 1ps
module triangle_face_normal_store_unit #(
  parameter int VERTEX_DEPTH = tfn_pkg::DEFAULT_VERTEX_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [15:0]        corner_first,
  input  logic [15:0]        corner_second,
  input  logic [15:0]        corner_third,
  input  logic [11:0]        query_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [1:0]         status
);
  import tfn_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);
  localparam int CW = $clog2(VERTEX_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_QRD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]    state;
  logic [1:0]    cnt;
  logic [CW-1:0] count;
  logic [AW-1:0] ia, ib, ic;
  logic [95:0]   va, vb;
  logic [47:0]   res_n;
  logic [1:0]    res_st;

  logic [95:0]   vmem [VERTEX_DEPTH];
  logic [47:0]   nmem [VERTEX_DEPTH];
  logic [95:0]   vrdata;
  logic [47:0]   nrdata;
  logic          vwe, nwe;
  logic [AW-1:0] vraddr, nwaddr, nraddr;
  logic [47:0]   nwdata;

  logic          accept, full, face_ok, query_ok, out_free;
  logic [IDX_W-1:0] cnt_x, ca, cb, cc, qx;

  xprod_ctl_t    xctl;
  xprod_t        xp;
  logic          xstart, nstart, ndone;
  logic [47:0]   nnorm;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign full     = (count == CW'(VERTEX_DEPTH));
  assign cnt_x    = IDX_W'(count);
  assign ca       = IDX_W'(corner_first) - IDX_W'(1);
  assign cb       = IDX_W'(corner_second) - IDX_W'(1);
  assign cc       = IDX_W'(corner_third) - IDX_W'(1);
  assign qx       = IDX_W'(query_index);
  assign face_ok  = (corner_first != '0) && (IDX_W'(corner_first) <= cnt_x)
                 && (corner_second != '0) && (IDX_W'(corner_second) <= cnt_x)
                 && (corner_third != '0) && (IDX_W'(corner_third) <= cnt_x);
  assign query_ok = (qx < cnt_x);

  assign vwe    = accept && (command == CMD_VERTEX) && !full;
  assign xstart = (state == S_RD) && (cnt == 2'd3);
  assign nstart = (state == S_CALC) && xctl.valid && !xctl.zero;
  assign nraddr = qx[AW-1:0];

  always_comb begin
    case (cnt)
      2'd0:    vraddr = ia;
      2'd1:    vraddr = ib;
      default: vraddr = ic;
    endcase
    nwe    = 1'b0;
    nwaddr = count[AW-1:0];
    nwdata = '0;
    if (vwe) begin
      nwe = 1'b1;
    end else if (state == S_WR) begin
      nwe    = 1'b1;
      nwdata = res_n;
      case (cnt)
        2'd0:    nwaddr = ia;
        2'd1:    nwaddr = ib;
        default: nwaddr = ic;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[count[AW-1:0]] <= {coord_z, coord_y, coord_x};
    vrdata <= vmem[vraddr];
  end

  always_ff @(posedge clk) begin
    if (nwe) nmem[nwaddr] <= nwdata;
    nrdata <= nmem[nraddr];
  end

  tfn_cross_unit u_cross (
    .clk   (clk),
    .rst   (rst),
    .start (xstart),
    .va    (va),
    .vb    (vb),
    .vc    (vrdata),
    .ctl   (xctl),
    .xprod (xp)
  );

  tfn_norm_unit u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (nstart),
    .xprod  (xp),
    .done   (ndone),
    .normal (nnorm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            res_n  <= '0;
            res_st <= ST_OK;
            case (command)
              CMD_VERTEX: begin
                if (full) res_st <= ST_FULL;
                else      count  <= count + CW'(1);
                state <= S_OUT;
              end
              CMD_FACE: begin
                ia <= ca[AW-1:0];
                ib <= cb[AW-1:0];
                ic <= cc[AW-1:0];
                if (face_ok) begin
                  state <= S_RD;
                end else begin
                  res_st <= ST_RANGE;
                  state  <= S_OUT;
                end
              end
              CMD_QUERY: begin
                if (query_ok) begin
                  state <= S_QRD;
                end else begin
                  res_st <= ST_RANGE;
                  state  <= S_OUT;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_RD: begin
          if (cnt == 2'd1) va <= vrdata;
          if (cnt == 2'd2) vb <= vrdata;
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) state <= S_CALC;
        end
        S_CALC: begin
          cnt <= '0;
          if (xctl.valid) begin
            if (xctl.zero) begin
              res_n  <= '0;
              res_st <= ST_DEGEN;
              state  <= S_WR;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (ndone) begin
            res_n  <= nnorm;
            res_st <= ST_OK;
            state  <= S_WR;
          end
        end
        S_WR: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd2) state <= S_OUT;
        end
        S_QRD: begin
          res_n <= nrdata;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      normal_x <= res_n[15:0];
      normal_y <= res_n[31:16];
      normal_z <= res_n[47:32];
      status   <= res_st;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(VERTEX_DEPTH)) else $error("vertex count beyond depth");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE) else $error("request accepted but unit idle");
  a_cross_in_calc: assert property (@(posedge clk) disable iff (rst)
    xctl.valid |-> state == S_CALC) else $error("cross result outside calc");
  a_norm_in_norm: assert property (@(posedge clk) disable iff (rst)
    ndone |-> state == S_NORM) else $error("normal done outside norm wait");
`endif
endmodule
